// File: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, codes and index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam idx_t LAST_IDX = IDX_W'(DEPTH - 1);
  localparam cnt_t FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_LIST_FWD   = 3'd4,
    MODE_LIST_BWD   = 3'd5
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  function automatic idx_t idx_next(input idx_t i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

endpackage

// File: src/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit values in a ring RAM.
// ----------------------------------------------------------------------------
// Each request names push front/back, pop front/back or a listing in either
// direction. Push and pop give one status result (ok, empty, full) and
// stream at one request per cycle while results are taken.
// A listing of n held elements gives n results, the last one marked on
// out_tlast, and keeps in_tready low until its last result is registered,
// also while results are held off: every element goes through the single
// read port of the RAM (ST_RD) and its registered read (ST_WAIT) before it
// reaches the result register. Listing an empty queue gives one empty result.
// Modes six and seven are taken and give no result.
module double_ended_queue_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [deq_pkg::DATA_W-1:0] in_tdata,  // [31:0] value
  input  logic [deq_pkg::MODE_W-1:0] in_tuser,  // [2:0] mode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [deq_pkg::DATA_W-1:0] out_tdata, // [31:0] item
  output logic [deq_pkg::STAT_W-1:0] out_tuser, // [1:0] status
  output logic                       out_tlast
);

  import deq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t  state_r, state_nxt;
  idx_t    front_r, front_nxt;
  idx_t    back_r, back_nxt;
  cnt_t    occ_r, occ_nxt;
  idx_t    pos_r, pos_nxt;
  cnt_t    cnt_r, cnt_nxt;
  logic    fwd_r, fwd_nxt;
  logic    ovalid_r, ovalid_nxt;
  data_t   odata_r, odata_nxt;
  status_t ostat_r, ostat_nxt;
  logic    olast_r, olast_nxt;

  logic    o_free;
  logic    accept;
  logic    full;
  logic    empty;
  logic    wr_en;
  idx_t    wr_addr;
  logic    rd_en;
  data_t   rd_data;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign o_free    = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && o_free;
  assign accept    = in_tvalid && in_tready;
  assign full      = (occ_r == FULL_CNT);
  assign empty     = (occ_r == '0);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    occ_nxt    = occ_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    fwd_nxt    = fwd_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ostat_nxt  = ostat_r;
    olast_nxt  = olast_r;
    wr_en      = 1'b0;
    wr_addr    = back_r;
    rd_en      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(in_tuser))
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              ovalid_nxt = 1'b1;
              odata_nxt  = '0;
              olast_nxt  = 1'b1;
              if (full) begin
                ostat_nxt = STAT_FULL;
              end else begin
                ostat_nxt = STAT_OK;
                wr_en     = 1'b1;
                occ_nxt   = occ_r + CNT_W'(1);
                if (mode_t'(in_tuser) == MODE_PUSH_FRONT) begin
                  wr_addr   = idx_prev(front_r);
                  front_nxt = idx_prev(front_r);
                end else begin
                  wr_addr  = back_r;
                  back_nxt = idx_next(back_r);
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              ovalid_nxt = 1'b1;
              odata_nxt  = '0;
              olast_nxt  = 1'b1;
              if (empty) begin
                ostat_nxt = STAT_EMPTY;
              end else begin
                ostat_nxt = STAT_OK;
                occ_nxt   = occ_r - CNT_W'(1);
                if (mode_t'(in_tuser) == MODE_POP_FRONT) begin
                  front_nxt = idx_next(front_r);
                end else begin
                  back_nxt = idx_prev(back_r);
                end
              end
            end
            MODE_LIST_FWD, MODE_LIST_BWD: begin
              if (empty) begin
                ovalid_nxt = 1'b1;
                odata_nxt  = '0;
                ostat_nxt  = STAT_EMPTY;
                olast_nxt  = 1'b1;
              end else begin
                fwd_nxt   = (mode_t'(in_tuser) == MODE_LIST_FWD);
                pos_nxt   = (mode_t'(in_tuser) == MODE_LIST_FWD) ? front_r
                                                                 : idx_prev(back_r);
                cnt_nxt   = occ_r;
                state_nxt = ST_RD;
              end
            end
            default: begin
              // unused modes are dropped
            end
          endcase
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (o_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = rd_data;
          ostat_nxt  = STAT_OK;
          olast_nxt  = (cnt_r == CNT_W'(1));
          cnt_nxt    = cnt_r - CNT_W'(1);
          pos_nxt    = fwd_r ? idx_next(pos_r) : idx_prev(pos_r);
          state_nxt  = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      front_r  <= '0;
      back_r   <= '0;
      occ_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      occ_r    <= occ_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    fwd_r   <= fwd_nxt;
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

endmodule

// File: src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [deq_pkg::MODE_W-1:0] in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [deq_pkg::DATA_W-1:0] out_tdata,
  input logic [deq_pkg::STAT_W-1:0] out_tuser,
  input logic                       out_tlast
);

  import deq_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // push and pop answer with one marked result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_PUSH_FRONT || in_tuser == MODE_PUSH_BACK
      || in_tuser == MODE_POP_FRONT || in_tuser == MODE_POP_BACK)
      |=> out_tvalid && out_tlast && (out_tdata == '0))
    else $error("push or pop result missing");

  // only listings give unmarked results, and those are ok
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tuser == STAT_OK) && !in_tready)
    else $error("unmarked result outside a listing");

  // an error status never carries an element
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> (out_tdata == '0) && out_tlast)
    else $error("error result carries data");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);

// File: bench/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// Self-checking bench for the double-ended queue: drives push, pop, listing
// and spare-mode requests with random idle gaps on both streams, mirrors the
// ring store in a shadow model and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import deq_pkg::*;

  // the two mode codes the block takes and drops without a result
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    data_t   item;
    status_t status;
    logic    last;
  } deq_result_t;

  class deque_tracker;
    data_t       slots [DEPTH];
    idx_t        head;
    idx_t        tail;
    cnt_t        fill;
    deq_result_t owed_results [$];
    int unsigned errors;

    function new();
      head   = '0;
      tail   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    function idx_t ring_fwd(input idx_t i);
      return (int'(i) + 1 >= DEPTH) ? idx_t'(0) : idx_t'(int'(i) + 1);
    endfunction

    function idx_t ring_back(input idx_t i);
      return (i == 0) ? idx_t'(DEPTH - 1) : idx_t'(int'(i) - 1);
    endfunction

    function void owe(input data_t item, input status_t status, input logic last);
      deq_result_t r;
      r.item   = item;
      r.status = status;
      r.last   = last;
      owed_results.push_back(r);
    endfunction

    // shadow the ring store and queue up the results this request causes
    function void note_request(input logic [MODE_W-1:0] mode, input data_t value);
      idx_t pos;
      int   n;
      case (mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (fill == FULL_CNT) begin
            owe('0, STAT_FULL, 1'b1);
          end else begin
            if (mode == MODE_PUSH_FRONT) begin
              head = ring_back(head);
              slots[head] = value;
            end else begin
              slots[tail] = value;
              tail = ring_fwd(tail);
            end
            fill++;
            owe('0, STAT_OK, 1'b1);
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (fill == 0) begin
            owe('0, STAT_EMPTY, 1'b1);
          end else begin
            if (mode == MODE_POP_FRONT) head = ring_fwd(head);
            else tail = ring_back(tail);
            fill--;
            owe('0, STAT_OK, 1'b1);
          end
        end
        MODE_LIST_FWD, MODE_LIST_BWD: begin
          if (fill == 0) begin
            owe('0, STAT_EMPTY, 1'b1);
          end else begin
            n   = int'(fill);
            pos = (mode == MODE_LIST_FWD) ? head : ring_back(tail);
            for (int k = 0; k < n; k++) begin
              owe(slots[pos], STAT_OK, k == n - 1);
              pos = (mode == MODE_LIST_FWD) ? ring_fwd(pos) : ring_back(pos);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(input data_t item, input logic [STAT_W-1:0] status,
                      input logic last);
      deq_result_t w;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result item=%0d status=%0d last=%0b",
                                  $signed(item), status, last));
      end else begin
        w = owed_results.pop_front();
        if (item !== w.item)
          report_mismatch($sformatf("item %0d, want %0d", $signed(item), $signed(w.item)));
        if (status !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", status, w.status));
        if (last !== w.last)
          report_mismatch($sformatf("last %0b, want %0b", last, w.last));
      end
    endtask

    function int pending();
      return owed_results.size();
    endfunction

    task flush_leftover();
      while (owed_results.size() != 0) begin
        void'(owed_results.pop_front());
        report_mismatch("result never arrived");
      end
    endtask
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  data_t             in_tdata   = '0;
  logic [MODE_W-1:0] in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  data_t             out_tdata;
  logic [STAT_W-1:0] out_tuser;
  logic              out_tlast;

  deque_tracker tracker = new();
  int unsigned  accepted_requests = 0;
  logic         idle_on  = 1'b1;
  logic         hold_off = 1'b0;

  double_ended_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function int gap_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function data_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task drive_request(input logic [MODE_W-1:0] mode, input data_t value);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accepted_requests++;
    tracker.note_request(mode, value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // sender
  initial begin
    int                counted;
    int                lean;
    int                r;
    logic [MODE_W-1:0] mode;
    logic              is_push;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, spare modes, fill to the brim, refused pushes, listings
    drive_request(MODE_POP_FRONT, $urandom);
    drive_request(MODE_POP_BACK, $urandom);
    drive_request(MODE_LIST_FWD, $urandom);
    drive_request(MODE_LIST_BWD, $urandom);
    drive_request(MODE_SPARE_A, $urandom);
    drive_request(MODE_SPARE_B, $urandom);
    drive_request(MODE_PUSH_FRONT, 32'h7fff_ffff);
    drive_request(MODE_PUSH_BACK, 32'h8000_0000);
    drive_request(MODE_PUSH_FRONT, '0);
    drive_request(MODE_PUSH_BACK, '1);
    for (int i = 4; i < DEPTH; i++)
      drive_request(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom);
    drive_request(MODE_PUSH_FRONT, $urandom);
    drive_request(MODE_PUSH_BACK, $urandom);
    drive_request(MODE_LIST_FWD, $urandom);
    drive_request(MODE_LIST_BWD, $urandom);

    // random phases that lean toward filling, draining or neither
    counted = 0;
    while (counted < 300) begin
      lean    = $urandom_range(0, 2);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < 40; j++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        end else begin
          if (r < 16) begin
            mode = $urandom_range(0, 1) ? MODE_LIST_FWD : MODE_LIST_BWD;
          end else begin
            r = $urandom_range(0, 99);
            is_push = (lean == 0) ? (r < 75) : (lean == 1) ? (r < 25) : (r < 50);
            if (is_push) mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            else mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
          end
          counted++;
        end
        drive_request(mode, pick_value());
      end
    end
    in_tvalid <= 1'b0;
    idle_on   <= 1'b1;

    while (tracker.pending() != 0) @(posedge clk);
    // give any stray extra result time to show up
    repeat (2 * DEPTH + 8) @(posedge clk);
    tracker.flush_leftover();
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        tracker.check_result(out_tdata, out_tuser, out_tlast);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = gap_len();
      out_tready <= rst_n && !hold_off && stall_left == 0;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (accepted_requests >= 120);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue_top.sv
src/deq_checker.sv
bench/tb_double_ended_queue_top.sv
